### rtl/core/i2cm_pkg.sv
// Shared types and constants for the I2C master register access core.
`default_nettype none

package i2cm_pkg;

    // Command codes carried in the input beat
    localparam logic [1:0] OP_TICK  = 2'd0;
    localparam logic [1:0] OP_WRITE = 2'd1;
    localparam logic [1:0] OP_READ  = 2'd2;
    localparam logic [1:0] OP_DATA  = 2'd3;

    // Completion status codes
    localparam logic [1:0] STAT_OK        = 2'd0;
    localparam logic [1:0] STAT_BUSY      = 2'd1;
    localparam logic [1:0] STAT_ADDR_NACK = 2'd2;
    localparam logic [1:0] STAT_DATA_NACK = 2'd3;

    // Configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_DELAY_TICKS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ACK_TIMEOUT = 2'd1;

    localparam logic [7:0] DELAY_TICKS_RST = 8'd1;
    localparam logic [7:0] ACK_TIMEOUT_RST = 8'd50;

    localparam int S_TDATA_W = 32;
    localparam int M_TDATA_W = 16;

    typedef struct packed {
        logic [7:0] delay_ticks;
        logic [7:0] ack_timeout;
    } cfg_t;

    typedef struct packed {
        logic [1:0] op;
        logic [6:0] dev_addr;
        logic [7:0] reg_addr;
        logic [7:0] length;
        logic [7:0] wr_byte;
        logic       sda_in;
    } item_t;

    typedef struct packed {
        logic       scl_level;
        logic       sda_pull_low;
        logic [7:0] rd_byte;
        logic       rd_valid;
        logic       rd_last;
        logic       wr_need;
        logic       done_res;
        logic [1:0] status;
        logic       busy_res;
    } result_t;

endpackage

`default_nettype wire

### rtl/core/i2c_master_register_access_core.sv
// I2C master register access core: stream wrapper around the bus sequencer.
// An accepted input beat is held in the input register, then its result in the result
// register, which drives the output.
// Throughput: one beat per cycle unless the result side stalls; each beat is
// one bus tick; sequencer state updates in the cycle the beat leaves the input register.
// Reset (aresetn low, synchronous): pipeline empty, sequencer idle, SCL and SDA released.
`default_nettype none

module i2c_master_register_access_core (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    // dev_addr[6:0], reg_addr[14:7], length[22:15], wr_byte[30:23], sda_in[31]
    input  wire logic [i2cm_pkg::S_TDATA_W-1:0] s_tdata,
    // op[1:0]
    input  wire logic [1:0]                     s_tuser,
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    // scl_level[0], sda_pull_low[1], rd_byte[9:2], rd_valid[10], wr_need[11],
    // done_res[12], status[14:13], busy_res[15]
    output logic [i2cm_pkg::M_TDATA_W-1:0]      m_tdata,
    output logic                                m_tlast,
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [i2cm_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [7:0]                     cfg_data
);

    i2cm_pkg::cfg_t    cfg;
    i2cm_pkg::item_t   item_reg;
    i2cm_pkg::result_t res;
    i2cm_pkg::result_t res_reg;
    logic              in_valid_reg;
    logic              out_valid_reg;
    logic              advance;
    logic              item_go;

    i2cm_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // Result register empty or draining this cycle
    assign advance  = !out_valid_reg || m_tready;
    assign item_go  = in_valid_reg && advance;
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            item_reg.op       <= s_tuser;
            item_reg.dev_addr <= s_tdata[6:0];
            item_reg.reg_addr <= s_tdata[14:7];
            item_reg.length   <= s_tdata[22:15];
            item_reg.wr_byte  <= s_tdata[30:23];
            item_reg.sda_in   <= s_tdata[31];
        end
    end

    i2cm_engine u_engine (
        .aclk    (aclk),
        .aresetn (aresetn),
        .item_go (item_go),
        .item    (item_reg),
        .cfg     (cfg),
        .res     (res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (item_go) begin
            res_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tlast  = res_reg.rd_last;
    assign m_tdata  = {res_reg.busy_res, res_reg.status, res_reg.done_res, res_reg.wr_need,
                       res_reg.rd_valid, res_reg.rd_byte, res_reg.sda_pull_low,
                       res_reg.scl_level};

endmodule

`default_nettype wire

### rtl/core/i2cm_cfg_regs.sv
// Configuration register file: delay unit length and acknowledge timeout.
`default_nettype none

module i2cm_cfg_regs (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [i2cm_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [7:0]                     cfg_data,
    output i2cm_pkg::cfg_t                      cfg
);

    logic [7:0] delay_ticks_reg;
    logic [7:0] ack_timeout_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            delay_ticks_reg <= i2cm_pkg::DELAY_TICKS_RST;
            ack_timeout_reg <= i2cm_pkg::ACK_TIMEOUT_RST;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                i2cm_pkg::CFG_DELAY_TICKS: delay_ticks_reg <= cfg_data;
                i2cm_pkg::CFG_ACK_TIMEOUT: ack_timeout_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    assign cfg.delay_ticks = delay_ticks_reg;
    assign cfg.ack_timeout = ack_timeout_reg;

endmodule

`default_nettype wire

### rtl/core/i2cm_engine.sv
// Bus sequencer: holds transaction state and advances it by one tick per beat.
`default_nettype none

module i2cm_engine (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              item_go,
    input  wire i2cm_pkg::item_t   item,
    input  wire i2cm_pkg::cfg_t    cfg,
    output i2cm_pkg::result_t      res
);

    typedef enum logic [3:0] {
        PH_IDLE, PH_START, PH_SEND, PH_ACKW, PH_WAITWR,
        PH_RESTART, PH_RECV, PH_RACK, PH_STOP
    } phase_t;

    typedef enum logic [1:0] {
        SG_ADDR, SG_REG, SG_RADDR, SG_DATA
    } stage_t;

    phase_t     phase_reg, phase_next;
    stage_t     stage_reg, stage_next;
    logic [2:0] sub_step_reg, sub_step_next;
    logic [3:0] bit_index_reg, bit_index_next;
    logic [7:0] shift_reg, shift_next;
    logic [7:0] bytes_left_reg, bytes_left_next;
    logic [7:0] wait_count_reg, wait_count_next;
    logic [7:0] tick_count_reg, tick_count_next;
    logic [6:0] held_device_reg, held_device_next;
    logic [7:0] held_register_reg, held_register_next;
    logic       is_read_reg, is_read_next;
    logic       scl_reg, scl_next;
    logic       sda_reg, sda_next;
    logic [1:0] result_code_reg, result_code_next;

    logic       done;
    logic       rdv;
    logic       rdl;
    logic [7:0] rdb;
    logic [1:0] code;
    logic [7:0] units;
    logic       ack_ok;
    logic [7:0] bytes_dec;

    always_comb begin
        phase_next         = phase_reg;
        stage_next         = stage_reg;
        sub_step_next      = sub_step_reg;
        bit_index_next     = bit_index_reg;
        shift_next         = shift_reg;
        bytes_left_next    = bytes_left_reg;
        wait_count_next    = wait_count_reg;
        tick_count_next    = tick_count_reg;
        held_device_next   = held_device_reg;
        held_register_next = held_register_reg;
        is_read_next       = is_read_reg;
        scl_next           = scl_reg;
        sda_next           = sda_reg;
        result_code_next   = result_code_reg;
        done               = 1'b0;
        rdv                = 1'b0;
        rdl                = 1'b0;
        rdb                = 8'd0;
        code               = i2cm_pkg::STAT_OK;
        ack_ok             = !item.sda_in;
        bytes_dec          = bytes_left_reg - 8'd1;
        units              = (cfg.delay_ticks == 8'd0) ? 8'd1 : cfg.delay_ticks;

        if (phase_reg == PH_IDLE) begin
            if (item.op == i2cm_pkg::OP_WRITE || item.op == i2cm_pkg::OP_READ) begin
                if (!item.sda_in) begin
                    // bus held low by someone else
                    done = 1'b1;
                    code = i2cm_pkg::STAT_BUSY;
                end else begin
                    held_device_next   = item.dev_addr;
                    held_register_next = item.reg_addr;
                    bytes_left_next    = item.length;
                    is_read_next       = (item.op == i2cm_pkg::OP_READ);
                    result_code_next   = i2cm_pkg::STAT_OK;
                    scl_next           = 1'b1;
                    sda_next           = 1'b1;
                    tick_count_next    = 8'd0;
                    phase_next         = PH_START;
                    sub_step_next      = 3'd0;
                end
            end
        end else if (phase_reg == PH_WAITWR) begin
            if (item.op == i2cm_pkg::OP_DATA) begin
                tick_count_next = 8'd0;
                shift_next      = item.wr_byte;
                stage_next      = SG_DATA;
                bit_index_next  = 4'd0;
                phase_next      = PH_SEND;
                sub_step_next   = 3'd0;
            end
        end else if ({1'b0, tick_count_reg} + 9'd1 < {1'b0, units}) begin
            tick_count_next = tick_count_reg + 8'd1;
        end else begin
            tick_count_next = 8'd0;
            case (phase_reg)
                PH_START: begin
                    if (sub_step_reg == 3'd0) begin
                        sda_next      = 1'b0;
                        sub_step_next = 3'd1;
                    end else if (item.sda_in) begin
                        // start did not take: release and report busy
                        sda_next      = 1'b1;
                        phase_next    = PH_IDLE;
                        sub_step_next = 3'd0;
                        done          = 1'b1;
                        code          = i2cm_pkg::STAT_BUSY;
                    end else begin
                        scl_next       = 1'b0;
                        shift_next     = {held_device_reg, 1'b0};
                        stage_next     = SG_ADDR;
                        bit_index_next = 4'd0;
                        phase_next     = PH_SEND;
                        sub_step_next  = 3'd0;
                    end
                end
                PH_SEND: begin
                    if (sub_step_reg == 3'd0) begin
                        sda_next      = shift_reg[7];
                        sub_step_next = 3'd1;
                    end else if (sub_step_reg == 3'd1) begin
                        scl_next      = 1'b1;
                        sub_step_next = 3'd2;
                    end else begin
                        scl_next   = 1'b0;
                        shift_next = {shift_reg[6:0], 1'b0};
                        if (bit_index_reg + 4'd1 >= 4'd8) begin
                            bit_index_next = 4'd0;
                            phase_next     = PH_ACKW;
                            sub_step_next  = 3'd0;
                        end else begin
                            bit_index_next = bit_index_reg + 4'd1;
                            sub_step_next  = 3'd0;
                        end
                    end
                end
                PH_ACKW: begin
                    if (sub_step_reg == 3'd0) begin
                        sda_next        = 1'b1;
                        wait_count_next = 8'd0;
                        sub_step_next   = 3'd1;
                    end else if (sub_step_reg == 3'd1) begin
                        scl_next      = 1'b1;
                        sub_step_next = 3'd2;
                    end else if (ack_ok || wait_count_reg >= cfg.ack_timeout) begin
                        scl_next      = 1'b0;
                        sub_step_next = 3'd0;
                        case (stage_reg)
                            SG_ADDR: begin
                                if (ack_ok) begin
                                    shift_next     = held_register_reg;
                                    stage_next     = SG_REG;
                                    bit_index_next = 4'd0;
                                    phase_next     = PH_SEND;
                                end else begin
                                    result_code_next = i2cm_pkg::STAT_ADDR_NACK;
                                    phase_next       = PH_STOP;
                                end
                            end
                            SG_REG: begin
                                // register ACK outcome is ignored
                                if (is_read_reg) begin
                                    phase_next = PH_RESTART;
                                end else if (bytes_left_reg == 8'd0) begin
                                    result_code_next = i2cm_pkg::STAT_OK;
                                    phase_next       = PH_STOP;
                                end else begin
                                    phase_next = PH_WAITWR;
                                end
                            end
                            SG_RADDR: begin
                                if (bytes_left_reg == 8'd0) begin
                                    result_code_next = i2cm_pkg::STAT_OK;
                                    phase_next       = PH_STOP;
                                end else begin
                                    bit_index_next = 4'd0;
                                    shift_next     = 8'd0;
                                    phase_next     = PH_RECV;
                                end
                            end
                            default: begin
                                if (!ack_ok) begin
                                    result_code_next = i2cm_pkg::STAT_DATA_NACK;
                                    phase_next       = PH_STOP;
                                end else begin
                                    bytes_left_next = bytes_dec;
                                    if (bytes_dec == 8'd0) begin
                                        result_code_next = i2cm_pkg::STAT_OK;
                                        phase_next       = PH_STOP;
                                    end else begin
                                        phase_next = PH_WAITWR;
                                    end
                                end
                            end
                        endcase
                    end else begin
                        wait_count_next = wait_count_reg + 8'd1;
                    end
                end
                PH_RESTART: begin
                    if (sub_step_reg == 3'd0) begin
                        sda_next      = 1'b1;
                        sub_step_next = 3'd1;
                    end else if (sub_step_reg == 3'd1) begin
                        scl_next      = 1'b1;
                        sub_step_next = 3'd2;
                    end else if (sub_step_reg == 3'd2) begin
                        sda_next      = 1'b0;
                        sub_step_next = 3'd3;
                    end else begin
                        scl_next       = 1'b0;
                        shift_next     = {held_device_reg, 1'b1};
                        stage_next     = SG_RADDR;
                        bit_index_next = 4'd0;
                        phase_next     = PH_SEND;
                        sub_step_next  = 3'd0;
                    end
                end
                PH_RECV: begin
                    if (sub_step_reg == 3'd0) begin
                        scl_next      = 1'b0;
                        sda_next      = 1'b1;
                        sub_step_next = 3'd1;
                    end else if (sub_step_reg == 3'd1) begin
                        sub_step_next = 3'd2;
                    end else if (sub_step_reg == 3'd2) begin
                        scl_next      = 1'b1;
                        sub_step_next = 3'd3;
                    end else begin
                        shift_next = {shift_reg[6:0], item.sda_in};
                        if (bit_index_reg + 4'd1 >= 4'd8) begin
                            bit_index_next = 4'd0;
                            phase_next     = PH_RACK;
                            sub_step_next  = 3'd0;
                        end else begin
                            bit_index_next = bit_index_reg + 4'd1;
                            sub_step_next  = 3'd0;
                        end
                    end
                end
                PH_RACK: begin
                    if (sub_step_reg == 3'd0) begin
                        // ACK all but the final byte, NACK the final one
                        scl_next      = 1'b0;
                        sda_next      = !(bytes_left_reg > 8'd1);
                        sub_step_next = 3'd1;
                    end else if (sub_step_reg == 3'd1) begin
                        scl_next      = 1'b1;
                        sub_step_next = 3'd2;
                    end else begin
                        scl_next      = 1'b0;
                        rdv           = 1'b1;
                        rdb           = shift_reg;
                        rdl           = (bytes_left_reg <= 8'd1);
                        shift_next    = 8'd0;
                        sub_step_next = 3'd0;
                        if (bytes_left_reg <= 8'd1) begin
                            bytes_left_next  = 8'd0;
                            result_code_next = i2cm_pkg::STAT_OK;
                            phase_next       = PH_STOP;
                        end else begin
                            bytes_left_next = bytes_dec;
                            phase_next      = PH_RECV;
                        end
                    end
                end
                PH_STOP: begin
                    if (sub_step_reg == 3'd0) begin
                        scl_next      = 1'b0;
                        sda_next      = 1'b0;
                        sub_step_next = 3'd1;
                    end else if (sub_step_reg == 3'd1) begin
                        scl_next      = 1'b1;
                        sub_step_next = 3'd2;
                    end else begin
                        sda_next      = 1'b1;
                        phase_next    = PH_IDLE;
                        sub_step_next = 3'd0;
                        done          = 1'b1;
                        code          = result_code_reg;
                    end
                end
                default: begin
                    scl_next      = 1'b1;
                    sda_next      = 1'b1;
                    phase_next    = PH_IDLE;
                    sub_step_next = 3'd0;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg         <= PH_IDLE;
            stage_reg         <= SG_ADDR;
            sub_step_reg      <= 3'd0;
            bit_index_reg     <= 4'd0;
            shift_reg         <= 8'd0;
            bytes_left_reg    <= 8'd0;
            wait_count_reg    <= 8'd0;
            tick_count_reg    <= 8'd0;
            held_device_reg   <= 7'd0;
            held_register_reg <= 8'd0;
            is_read_reg       <= 1'b0;
            scl_reg           <= 1'b1;
            sda_reg           <= 1'b1;
            result_code_reg   <= i2cm_pkg::STAT_OK;
        end else if (item_go) begin
            phase_reg         <= phase_next;
            stage_reg         <= stage_next;
            sub_step_reg      <= sub_step_next;
            bit_index_reg     <= bit_index_next;
            shift_reg         <= shift_next;
            bytes_left_reg    <= bytes_left_next;
            wait_count_reg    <= wait_count_next;
            tick_count_reg    <= tick_count_next;
            held_device_reg   <= held_device_next;
            held_register_reg <= held_register_next;
            is_read_reg       <= is_read_next;
            scl_reg           <= scl_next;
            sda_reg           <= sda_next;
            result_code_reg   <= result_code_next;
        end
    end

    assign res.scl_level    = scl_next;
    assign res.sda_pull_low = !sda_next;
    assign res.rd_byte      = rdb;
    assign res.rd_valid     = rdv;
    assign res.rd_last      = rdv && rdl;
    assign res.wr_need      = (phase_next == PH_WAITWR);
    assign res.done_res     = done;
    assign res.status       = done ? code : i2cm_pkg::STAT_OK;
    assign res.busy_res     = (phase_next != PH_IDLE);

    // Sequencer moves only on an accepted tick
    a_hold_without_tick: assert property (@(posedge aclk) disable iff (!aresetn)
        !item_go |=> $stable(phase_reg) && $stable(tick_count_reg))
        else $error("engine state moved without a tick");

    // Bit counter wraps at eight
    a_bit_index_range: assert property (@(posedge aclk) disable iff (!aresetn)
        bit_index_reg <= 4'd7)
        else $error("bit index out of range");

    // Data NACK can only end a write
    a_data_nack_write_only: assert property (@(posedge aclk) disable iff (!aresetn)
        item_go && done && code == i2cm_pkg::STAT_DATA_NACK |-> !is_read_reg)
        else $error("data nack reported on a read");

    // Idle leaves the delay counter cleared
    a_idle_tick_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg == PH_IDLE |-> tick_count_reg == 8'd0)
        else $error("tick counter running while idle");

endmodule

`default_nettype wire

### verif/i2c_master_register_access_core_test.sv
// Stream-level test of the I2C master register access core against a cycle-free bus predictor.
`timescale 1ns / 100ps

module i2c_master_register_access_core_test;

    localparam int STALL_LIMIT = 2000;

    typedef enum logic [3:0] {
        BUS_IDLE, BUS_START, BUS_SEND, BUS_ACKW, BUS_WAITWR,
        BUS_RESTART, BUS_RECV, BUS_RACK, BUS_STOP
    } bus_phase_t;

    typedef enum logic [1:0] {STG_ADDR, STG_REG, STG_RADDR, STG_DATA} byte_stage_t;

    // Tracks the bus sequencer tick by tick and holds the result beats still owed.
    class i2c_bus_tracker_t;
        bit [7:0]          unit_len;
        bit [7:0]          poll_limit;
        bus_phase_t        ph;
        bit [2:0]          step;
        bit [3:0]          bit_cnt;
        bit [7:0]          shreg;
        bit [7:0]          remaining;
        bit [7:0]          polls;
        bit [7:0]          ticks;
        bit [6:0]          dev;
        bit [7:0]          regad;
        bit                rd_mode;
        bit                scl_q;
        bit                sda_q;
        byte_stage_t       stg;
        bit [1:0]          end_code;
        i2cm_pkg::result_t owed_beats[$];
        int                errors;

        function new();
            unit_len   = i2cm_pkg::DELAY_TICKS_RST;
            poll_limit = i2cm_pkg::ACK_TIMEOUT_RST;
            ph         = BUS_IDLE;
            step       = 3'd0;
            bit_cnt    = 4'd0;
            shreg      = 8'd0;
            remaining  = 8'd0;
            polls      = 8'd0;
            ticks      = 8'd0;
            dev        = 7'd0;
            regad      = 8'd0;
            rd_mode    = 1'b0;
            scl_q      = 1'b1;
            sda_q      = 1'b1;
            stg        = STG_ADDR;
            end_code   = i2cm_pkg::STAT_OK;
            errors     = 0;
        endfunction

        function void set_reg(logic [i2cm_pkg::CFG_IDX_W-1:0] idx, logic [7:0] val);
            case (idx)
                i2cm_pkg::CFG_DELAY_TICKS: unit_len = val;
                i2cm_pkg::CFG_ACK_TIMEOUT: poll_limit = val;
                default: ;
            endcase
        endfunction

        function void enter(bus_phase_t p);
            ph   = p;
            step = 3'd0;
        endfunction

        function void load_byte(bit [7:0] b, byte_stage_t s);
            shreg   = b;
            stg     = s;
            bit_cnt = 4'd0;
            enter(BUS_SEND);
        endfunction

        function void start_stop(bit [1:0] code);
            end_code = code;
            enter(BUS_STOP);
        endfunction

        function void ack_done(bit ok);
            scl_q = 1'b0;
            case (stg)
                STG_ADDR: begin
                    if (ok) load_byte(regad, STG_REG);
                    else start_stop(i2cm_pkg::STAT_ADDR_NACK);
                end
                STG_REG: begin
                    if (rd_mode) enter(BUS_RESTART);
                    else if (remaining == 0) start_stop(i2cm_pkg::STAT_OK);
                    else enter(BUS_WAITWR);
                end
                STG_RADDR: begin
                    if (remaining == 0) start_stop(i2cm_pkg::STAT_OK);
                    else begin
                        bit_cnt = 4'd0;
                        shreg   = 8'd0;
                        enter(BUS_RECV);
                    end
                end
                default: begin
                    if (!ok) start_stop(i2cm_pkg::STAT_DATA_NACK);
                    else begin
                        remaining = remaining - 8'd1;
                        if (remaining == 0) start_stop(i2cm_pkg::STAT_OK);
                        else enter(BUS_WAITWR);
                    end
                end
            endcase
        endfunction

        function i2cm_pkg::result_t advance(i2cm_pkg::item_t it);
            i2cm_pkg::result_t r;
            bit                done;
            bit                rdv;
            bit                rdl;
            bit [7:0]          rdb;
            bit [1:0]          code;
            int                units;
            done  = 1'b0;
            rdv   = 1'b0;
            rdl   = 1'b0;
            rdb   = 8'd0;
            code  = i2cm_pkg::STAT_OK;
            units = (unit_len == 0) ? 1 : int'(unit_len);

            if (ph == BUS_IDLE) begin
                if (it.op == i2cm_pkg::OP_WRITE || it.op == i2cm_pkg::OP_READ) begin
                    if (!it.sda_in) begin
                        done = 1'b1;
                        code = i2cm_pkg::STAT_BUSY;
                    end else begin
                        dev       = it.dev_addr;
                        regad     = it.reg_addr;
                        remaining = it.length;
                        rd_mode   = (it.op == i2cm_pkg::OP_READ);
                        end_code  = i2cm_pkg::STAT_OK;
                        scl_q     = 1'b1;
                        sda_q     = 1'b1;
                        ticks     = 8'd0;
                        enter(BUS_START);
                    end
                end
            end else if (ph == BUS_WAITWR) begin
                if (it.op == i2cm_pkg::OP_DATA) begin
                    ticks = 8'd0;
                    load_byte(it.wr_byte, STG_DATA);
                end
            end else if (int'(ticks) + 1 < units) begin
                ticks = ticks + 8'd1;
            end else begin
                ticks = 8'd0;
                case (ph)
                    BUS_START: begin
                        if (step == 0) begin
                            sda_q = 1'b0;
                            step  = 3'd1;
                        end else if (it.sda_in) begin
                            // line never went low: someone else holds the bus
                            sda_q = 1'b1;
                            enter(BUS_IDLE);
                            done = 1'b1;
                            code = i2cm_pkg::STAT_BUSY;
                        end else begin
                            scl_q = 1'b0;
                            load_byte({dev, 1'b0}, STG_ADDR);
                        end
                    end
                    BUS_SEND: begin
                        if (step == 0) begin
                            sda_q = shreg[7];
                            step  = 3'd1;
                        end else if (step == 1) begin
                            scl_q = 1'b1;
                            step  = 3'd2;
                        end else begin
                            scl_q   = 1'b0;
                            shreg   = shreg << 1;
                            bit_cnt = bit_cnt + 4'd1;
                            if (bit_cnt >= 8) begin
                                bit_cnt = 4'd0;
                                enter(BUS_ACKW);
                            end else step = 3'd0;
                        end
                    end
                    BUS_ACKW: begin
                        if (step == 0) begin
                            sda_q = 1'b1;
                            polls = 8'd0;
                            step  = 3'd1;
                        end else if (step == 1) begin
                            scl_q = 1'b1;
                            step  = 3'd2;
                        end else if (!it.sda_in) ack_done(1'b1);
                        else if (polls >= poll_limit) ack_done(1'b0);
                        else polls = polls + 8'd1;
                    end
                    BUS_RESTART: begin
                        if (step == 0) begin
                            sda_q = 1'b1;
                            step  = 3'd1;
                        end else if (step == 1) begin
                            scl_q = 1'b1;
                            step  = 3'd2;
                        end else if (step == 2) begin
                            sda_q = 1'b0;
                            step  = 3'd3;
                        end else begin
                            scl_q = 1'b0;
                            load_byte({dev, 1'b1}, STG_RADDR);
                        end
                    end
                    BUS_RECV: begin
                        if (step == 0) begin
                            scl_q = 1'b0;
                            sda_q = 1'b1;
                            step  = 3'd1;
                        end else if (step == 1) step = 3'd2;
                        else if (step == 2) begin
                            scl_q = 1'b1;
                            step  = 3'd3;
                        end else begin
                            shreg   = {shreg[6:0], it.sda_in};
                            bit_cnt = bit_cnt + 4'd1;
                            if (bit_cnt >= 8) begin
                                bit_cnt = 4'd0;
                                enter(BUS_RACK);
                            end else step = 3'd0;
                        end
                    end
                    BUS_RACK: begin
                        if (step == 0) begin
                            // ACK all but the last byte
                            scl_q = 1'b0;
                            sda_q = (remaining > 1) ? 1'b0 : 1'b1;
                            step  = 3'd1;
                        end else if (step == 1) begin
                            scl_q = 1'b1;
                            step  = 3'd2;
                        end else begin
                            scl_q     = 1'b0;
                            rdv       = 1'b1;
                            rdb       = shreg;
                            rdl       = (remaining <= 1);
                            remaining = (remaining != 0) ? remaining - 8'd1 : 8'd0;
                            shreg     = 8'd0;
                            if (remaining == 0) start_stop(i2cm_pkg::STAT_OK);
                            else enter(BUS_RECV);
                        end
                    end
                    BUS_STOP: begin
                        if (step == 0) begin
                            scl_q = 1'b0;
                            sda_q = 1'b0;
                            step  = 3'd1;
                        end else if (step == 1) begin
                            scl_q = 1'b1;
                            step  = 3'd2;
                        end else begin
                            sda_q = 1'b1;
                            enter(BUS_IDLE);
                            done = 1'b1;
                            code = end_code;
                        end
                    end
                    default: begin
                        scl_q = 1'b1;
                        sda_q = 1'b1;
                        enter(BUS_IDLE);
                    end
                endcase
            end

            r.scl_level    = scl_q;
            r.sda_pull_low = !sda_q;
            r.rd_byte      = rdv ? rdb : 8'd0;
            r.rd_valid     = rdv;
            r.rd_last      = rdv && rdl;
            r.wr_need      = (ph == BUS_WAITWR);
            r.done_res     = done;
            r.status       = done ? code : i2cm_pkg::STAT_OK;
            r.busy_res     = (ph != BUS_IDLE);
            return r;
        endfunction

        function void take_tick(i2cm_pkg::item_t it);
            owed_beats.push_back(advance(it));
        endfunction

        function void field_ok(string name, logic [7:0] want, logic [7:0] got);
            if (got !== want) begin
                $error("%s: expected %0h, got %0h", name, want, got);
                errors++;
            end
        endfunction

        function void compare_beat(logic [i2cm_pkg::M_TDATA_W-1:0] d, logic last);
            i2cm_pkg::result_t e;
            if (owed_beats.size() == 0) begin
                $error("result beat %h arrived with no tick outstanding", d);
                errors++;
                return;
            end
            e = owed_beats.pop_front();
            field_ok("scl_level", 8'(e.scl_level), 8'(d[0]));
            field_ok("sda_pull_low", 8'(e.sda_pull_low), 8'(d[1]));
            field_ok("rd_byte", e.rd_byte, d[9:2]);
            field_ok("rd_valid", 8'(e.rd_valid), 8'(d[10]));
            field_ok("rd_last", 8'(e.rd_last), 8'(last));
            field_ok("wr_need", 8'(e.wr_need), 8'(d[11]));
            field_ok("done_res", 8'(e.done_res), 8'(d[12]));
            field_ok("status", 8'(e.status), 8'(d[14:13]));
            field_ok("busy_res", 8'(e.busy_res), 8'(d[15]));
        endfunction
    endclass

    logic                            aclk      = 1'b0;
    logic                            aresetn   = 1'b0;
    logic                            s_tvalid  = 1'b0;
    logic                            s_tready;
    logic [i2cm_pkg::S_TDATA_W-1:0]  s_tdata   = '0;
    logic [1:0]                      s_tuser   = i2cm_pkg::OP_TICK;
    logic                            m_tvalid;
    logic                            m_tready  = 1'b0;
    logic [i2cm_pkg::M_TDATA_W-1:0]  m_tdata;
    logic                            m_tlast;
    logic                            cfg_valid = 1'b0;
    logic                            cfg_ready;
    logic [i2cm_pkg::CFG_IDX_W-1:0]  cfg_index = i2cm_pkg::CFG_DELAY_TICKS;
    logic [7:0]                      cfg_data  = '0;

    i2c_bus_tracker_t tracker = new();
    bit               calm;
    bit               refuse_ack;

    always #10 aclk = ~aclk;

    i2c_master_register_access_core dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    function automatic i2cm_pkg::item_t mk(logic [1:0] op, logic [6:0] dv, logic [7:0] ra,
                                           logic [7:0] len, logic [7:0] wb, logic sda);
        i2cm_pkg::item_t it;
        it.op       = op;
        it.dev_addr = dv;
        it.reg_addr = ra;
        it.length   = len;
        it.wr_byte  = wb;
        it.sda_in   = sda;
        return it;
    endfunction

    // Act as the target on the bus: ACK, feed read data, and now and then misbehave.
    function automatic i2cm_pkg::item_t pick_tick(bit draining);
        i2cm_pkg::item_t it;
        int              roll;
        it.op       = i2cm_pkg::OP_TICK;
        it.dev_addr = 7'($urandom_range(0, 127));
        it.reg_addr = 8'($urandom_range(0, 255));
        it.length   = 8'($urandom_range(0, 255));
        it.wr_byte  = 8'($urandom_range(0, 255));
        it.sda_in   = 1'($urandom_range(0, 1));
        if (!draining && $urandom_range(0, 19) == 0) begin
            it.op = 2'($urandom_range(0, 3));
            // keep stray reads short
            if (tracker.ph == BUS_IDLE && it.op == i2cm_pkg::OP_READ) it.length[7:2] = '0;
            return it;
        end
        if (tracker.ph == BUS_ACKW && tracker.step == 0)
            refuse_ack = draining ? (tracker.stg == STG_DATA) : ($urandom_range(0, 9) == 0);
        if (tracker.ph != BUS_IDLE && tracker.ph != BUS_WAITWR && $urandom_range(0, 7) == 0)
            it.op = 2'($urandom_range(1, 3));
        case (tracker.ph)
            BUS_IDLE: begin
                if (!draining && $urandom_range(0, 2) == 0) begin
                    it.op  = $urandom_range(0, 1) ? i2cm_pkg::OP_WRITE : i2cm_pkg::OP_READ;
                    roll   = int'($urandom_range(0, 99));
                    if (roll < 70) it.length = 8'($urandom_range(0, 3));
                    else if (roll < 95) it.length = 8'($urandom_range(4, 12));
                    else if (it.op == i2cm_pkg::OP_WRITE) it.length = 8'($urandom_range(0, 255));
                    else it.length = 8'($urandom_range(0, 3));
                    it.sda_in = ($urandom_range(0, 9) != 0);
                end
            end
            BUS_WAITWR: begin
                if (draining || $urandom_range(0, 9) < 7) it.op = i2cm_pkg::OP_DATA;
                else it.op = 2'($urandom_range(0, 2));
            end
            BUS_START: begin
                if (tracker.step == 1) it.sda_in = ($urandom_range(0, 11) == 0);
                else it.sda_in = tracker.sda_q;
            end
            BUS_ACKW: begin
                if (tracker.step == 2)
                    it.sda_in = refuse_ack ? 1'b1 : ($urandom_range(0, 2) == 0);
            end
            BUS_RECV: ;
            default: begin
                if ($urandom_range(0, 7) != 0) it.sda_in = tracker.sda_q;
            end
        endcase
        return it;
    endfunction

    // Called at a falling edge; returns at the falling edge after the beat is taken.
    task automatic send_tick(i2cm_pkg::item_t it);
        if (!calm && $urandom_range(0, 9) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {it.sda_in, it.wr_byte, it.length, it.reg_addr, it.dev_addr};
        s_tuser  <= it.op;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        tracker.take_tick(it);
        @(negedge aclk);
    endtask

    task automatic write_regs(logic [7:0] delay_val, logic [7:0] timeout_val);
        cfg_valid <= 1'b1;
        cfg_index <= i2cm_pkg::CFG_DELAY_TICKS;
        cfg_data  <= delay_val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        tracker.set_reg(i2cm_pkg::CFG_DELAY_TICKS, delay_val);
        @(negedge aclk);
        cfg_index <= i2cm_pkg::CFG_ACK_TIMEOUT;
        cfg_data  <= timeout_val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        tracker.set_reg(i2cm_pkg::CFG_ACK_TIMEOUT, timeout_val);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // Random ticks, then drain the result side; with settle set, finish any open
    // transaction first so the core is idle for the next setting.
    task automatic run_phase(int count, bit settle);
        for (int i = 0; i < count; i++) send_tick(pick_tick(1'b0));
        if (settle)
            while (tracker.ph != BUS_IDLE) send_tick(pick_tick(1'b1));
        s_tvalid <= 1'b0;
        while (tracker.owed_beats.size() != 0) @(negedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) tracker.compare_beat(m_tdata, m_tlast);
    end

    initial begin : result_sink
        int n;
        @(negedge aclk);
        forever begin
            if (!calm && $urandom_range(0, 5) == 0) begin
                m_tready <= 1'b0;
                n = int'($urandom_range(1, 12));
            end else begin
                m_tready <= 1'b1;
                n = int'($urandom_range(1, 30));
            end
            repeat (n) @(negedge aclk);
        end
    end

    initial begin : watchdog
        int dead_cycles;
        dead_cycles = 0;
        while (dead_cycles < STALL_LIMIT) begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
                dead_cycles = 0;
            else
                dead_cycles++;
        end
        $display("end of test: mismatches");
        $finish;
    end

    initial begin : main
        i2cm_pkg::item_t opening[10];
        opening[0] = mk(i2cm_pkg::OP_TICK,  7'd0,   8'd0,   8'd0,   8'd0,   1'b0);
        // stray byte when idle
        opening[1] = mk(i2cm_pkg::OP_DATA,  7'd127, 8'd255, 8'd255, 8'd255, 1'b1);
        // bus busy at begin
        opening[2] = mk(i2cm_pkg::OP_WRITE, 7'd127, 8'd255, 8'd255, 8'd255, 1'b0);
        opening[3] = mk(i2cm_pkg::OP_READ,  7'd0,   8'd0,   8'd0,   8'd0,   1'b0);
        opening[4] = mk(i2cm_pkg::OP_WRITE, 7'd0,   8'd0,   8'd0,   8'd0,   1'b1);
        // ignored while busy
        opening[5] = mk(i2cm_pkg::OP_READ,  7'd55,  8'd170, 8'd3,   8'd85,  1'b0);
        opening[6] = mk(i2cm_pkg::OP_TICK,  7'd0,   8'd0,   8'd0,   8'd0,   1'b1);
        // read start on a free bus
        opening[7] = mk(i2cm_pkg::OP_READ,  7'd127, 8'd0,   8'd1,   8'd0,   1'b1);
        opening[8] = mk(i2cm_pkg::OP_WRITE, 7'd0,   8'd255, 8'd0,   8'd0,   1'b0);
        opening[9] = mk(i2cm_pkg::OP_DATA,  7'd42,  8'd17,  8'd9,   8'd200, 1'b0);

        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        foreach (opening[i]) send_tick(opening[i]);
        run_phase(300, 1'b0);

        write_regs(8'd1, 8'd1);
        run_phase(250, 1'b0);

        // zero delay behaves as one tick per unit
        write_regs(8'd0, 8'd255);
        run_phase(250, 1'b0);

        write_regs(8'd3, 8'd4);
        run_phase(350, 1'b0);

        calm = 1'b1;
        write_regs(8'd2, 8'd7);
        run_phase(200, 1'b0);

        write_regs(8'd255, 8'd128);
        run_phase(100, 1'b0);

        if (tracker.errors == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

### files.f
rtl/core/i2cm_pkg.sv
rtl/core/i2cm_cfg_regs.sv
rtl/core/i2cm_engine.sv
rtl/core/i2c_master_register_access_core.sv
verif/i2c_master_register_access_core_test.sv
